/* sv/acf_pkg.sv */
package acf_pkg;

   localparam int DATA_W       = 8;
   localparam int MIN_LEN_W    = 6;
   // Frame index and length width; covers every supported frame size up to 63.
   localparam int LEN_W        = 6;
   localparam int MAX_FRAME_DEF = 56;
   localparam int HDR_LEN      = 7;
   localparam int FIRST_COPIED = 3;
   localparam int MIN_HDR_IDX  = 6;

   localparam logic [MIN_LEN_W-1:0] MIN_LEN_RESET = MIN_LEN_W'(26);

   localparam logic [DATA_W-1:0] START_BYTE = 8'h65;
   localparam logic [DATA_W-1:0] CR_BYTE    = 8'h0D;
   localparam logic [DATA_W-1:0] CHAR_F     = 8'h46;
   localparam logic [DATA_W-1:0] CHAR_1     = 8'h31;

   typedef struct packed {
      logic             bank;
      logic [LEN_W-1:0] len;
   } job_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_HDR,
      BK_BODY,
      BK_TAIL
   } back_state_type;

   function automatic logic [DATA_W-1:0] hdr_byte(input logic [2:0] idx);
      logic [DATA_W-1:0] b;
      unique case (idx)
         3'd0: b = 8'h24;   // '$'
         3'd1: b = 8'h5F;   // '_'
         3'd2: b = 8'h5F;   // '_'
         3'd3: b = 8'h43;   // 'C'
         3'd4: b = 8'h41;   // 'A'
         3'd5: b = 8'h4E;   // 'N'
         default: b = 8'h2C; // ','
      endcase
      return b;
   endfunction

endpackage

/* sv/acf_chan_if.sv */
interface acf_req_if;
   logic                         valid;
   logic                         ready;
   logic [acf_pkg::DATA_W-1:0]   rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface acf_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [acf_pkg::DATA_W-1:0]   out_byte;
   logic                         out_last;

   modport source (output valid, output out_byte, output out_last, input ready);
   modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

/* sv/acf_ram.sv */
module acf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

endmodule

/* sv/acf_front.sv */
module acf_front #(
   parameter int MAX_FRAME = acf_pkg::MAX_FRAME_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   acf_req_if.sink                             req_ch,
   input  logic                                csr_wr_en,
   input  logic [acf_pkg::MIN_LEN_W-1:0]       csr_wr_data,
   input  logic                                bank_free,
   output logic                                ram_we,
   output logic [$clog2(MAX_FRAME):0]          ram_waddr,
   output logic [acf_pkg::DATA_W-1:0]          ram_wdata,
   output logic                                push,
   output acf_pkg::job_type                    push_job
);

   localparam int IDX_W = $clog2(MAX_FRAME);

   logic [acf_pkg::MIN_LEN_W-1:0] min_len_ff, min_len_in;
   logic [acf_pkg::LEN_W-1:0]     count_ff, count_in;
   logic                          in_frame_ff, in_frame_in;
   logic                          bank_ff, bank_in;
   logic [2:0]                    match_ff, match_in;
   logic                          take;
   logic [acf_pkg::LEN_W-1:0]     count_nx;
   logic [acf_pkg::DATA_W-1:0]    b;

   assign req_ch.ready = bank_free;
   assign take         = req_ch.valid & bank_free;
   assign b            = req_ch.rx_byte;
   assign count_nx     = count_ff + acf_pkg::LEN_W'(1);

   always_comb begin
      min_len_in  = csr_wr_en ? csr_wr_data : min_len_ff;
      count_in    = count_ff;
      in_frame_in = in_frame_ff;
      bank_in     = bank_ff;
      match_in    = match_ff;
      ram_we      = 1'b0;
      ram_waddr   = {bank_ff, count_ff[IDX_W-1:0]};
      ram_wdata   = b;
      push        = 1'b0;
      push_job    = '{bank: bank_ff, len: count_ff};

      if (take) begin
         if (!in_frame_ff) begin
            if (b == acf_pkg::START_BYTE) begin
               ram_we      = 1'b1;
               ram_waddr   = {bank_ff, {IDX_W{1'b0}}};
               count_in    = acf_pkg::LEN_W'(1);
               in_frame_in = 1'b1;
               match_in    = 3'b000;
            end
         end else if (b == acf_pkg::CR_BYTE) begin
            // A frame counts only when long enough and its bytes 3..5 read "F11".
            if (count_ff >= acf_pkg::LEN_W'(min_len_ff) &&
                count_ff >= acf_pkg::LEN_W'(acf_pkg::MIN_HDR_IDX) &&
                match_ff == 3'b111) begin
               push    = 1'b1;
               bank_in = ~bank_ff;
            end
            in_frame_in = 1'b0;
            count_in    = '0;
         end else begin
            ram_we = 1'b1;
            if (count_ff == acf_pkg::LEN_W'(3)) begin
               match_in[0] = (b == acf_pkg::CHAR_F);
            end
            if (count_ff == acf_pkg::LEN_W'(4)) begin
               match_in[1] = (b == acf_pkg::CHAR_1);
            end
            if (count_ff == acf_pkg::LEN_W'(5)) begin
               match_in[2] = (b == acf_pkg::CHAR_1);
            end
            if (count_nx == acf_pkg::LEN_W'(MAX_FRAME)) begin
               in_frame_in = 1'b0;
               count_in    = '0;
            end else begin
               count_in = count_nx;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_len_ff  <= acf_pkg::MIN_LEN_RESET;
         count_ff    <= '0;
         in_frame_ff <= 1'b0;
         bank_ff     <= 1'b0;
      end else begin
         min_len_ff  <= min_len_in;
         count_ff    <= count_in;
         in_frame_ff <= in_frame_in;
         bank_ff     <= bank_in;
      end
      match_ff <= match_in;
   end

endmodule

/* sv/acf_queue.sv */
module acf_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  acf_pkg::job_type push_job,
   input  logic             pop,
   output acf_pkg::job_type head,
   output logic [1:0]       count_ff
);

   acf_pkg::job_type slot_ff [2];
   acf_pkg::job_type slot_in [2];
   logic [1:0]       count_in;

   assign head = slot_ff[0];

   always_comb begin
      slot_in[0] = slot_ff[0];
      slot_in[1] = slot_ff[1];
      count_in   = count_ff;
      if (pop) begin
         slot_in[0] = slot_ff[1];
         count_in   = count_ff - 2'd1;
      end
      if (push) begin
         if (pop) begin
            // The new job takes the slot that the old tail held.
            slot_in[~count_ff[0]] = push_job;
            count_in              = count_ff;
         end else begin
            slot_in[count_ff[0]] = push_job;
            count_in             = count_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      slot_ff[0] <= slot_in[0];
      slot_ff[1] <= slot_in[1];
   end

endmodule

/* sv/acf_back.sv */
module acf_back #(
   parameter int MAX_FRAME = acf_pkg::MAX_FRAME_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          job_ready,
   input  acf_pkg::job_type              job,
   output logic                          pop,
   output logic                          busy,
   output logic                          ram_re,
   output logic [$clog2(MAX_FRAME):0]    ram_raddr,
   input  logic [acf_pkg::DATA_W-1:0]    ram_rdata,
   acf_rsp_if.source                     rsp_ch
);

   localparam int IDX_W = $clog2(MAX_FRAME);

   acf_pkg::back_state_type    state_ff, state_in;
   acf_pkg::job_type           job_ff, job_in;
   logic [acf_pkg::LEN_W-1:0]  cnt_ff, cnt_in;
   logic [acf_pkg::LEN_W-1:0]  cnt_nx;
   logic                       valid_ff, valid_in;
   logic [acf_pkg::DATA_W-1:0] byte_ff, byte_in;
   logic                       last_ff, last_in;
   logic                       out_free;
   logic                       load;

   assign out_free        = ~valid_ff | rsp_ch.ready;
   assign cnt_nx          = cnt_ff + acf_pkg::LEN_W'(1);
   assign busy            = (state_ff != acf_pkg::BK_IDLE);
   assign rsp_ch.valid    = valid_ff;
   assign rsp_ch.out_byte = byte_ff;
   assign rsp_ch.out_last = last_ff;

   always_comb begin
      state_in  = state_ff;
      job_in    = job_ff;
      cnt_in    = cnt_ff;
      pop       = 1'b0;
      ram_re    = 1'b0;
      ram_raddr = {job_ff.bank, cnt_nx[IDX_W-1:0]};
      load      = 1'b0;
      byte_in   = byte_ff;
      last_in   = last_ff;

      unique case (state_ff)
         acf_pkg::BK_IDLE: begin
            if (job_ready) begin
               pop      = 1'b1;
               job_in   = job;
               cnt_in   = '0;
               state_in = acf_pkg::BK_HDR;
            end
         end
         acf_pkg::BK_HDR: begin
            if (out_free) begin
               load    = 1'b1;
               byte_in = acf_pkg::hdr_byte(cnt_ff[2:0]);
               last_in = 1'b0;
               if (cnt_ff == acf_pkg::LEN_W'(acf_pkg::HDR_LEN - 1)) begin
                  // Fetch the first copied frame byte into the RAM read register for the body state.
                  ram_re    = 1'b1;
                  ram_raddr = {job_ff.bank, IDX_W'(acf_pkg::FIRST_COPIED)};
                  cnt_in    = acf_pkg::LEN_W'(acf_pkg::FIRST_COPIED);
                  state_in  = acf_pkg::BK_BODY;
               end else begin
                  cnt_in = cnt_nx;
               end
            end
         end
         acf_pkg::BK_BODY: begin
            if (out_free) begin
               load    = 1'b1;
               byte_in = ram_rdata;
               last_in = 1'b0;
               if (cnt_nx < job_ff.len) begin
                  ram_re = 1'b1;
                  cnt_in = cnt_nx;
               end else begin
                  state_in = acf_pkg::BK_TAIL;
               end
            end
         end
         acf_pkg::BK_TAIL: begin
            if (out_free) begin
               load     = 1'b1;
               byte_in  = acf_pkg::CR_BYTE;
               last_in  = 1'b1;
               state_in = acf_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = acf_pkg::BK_IDLE;
         end
      endcase

      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= acf_pkg::BK_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      job_ff  <= job_in;
      cnt_ff  <= cnt_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

endmodule

/* sv/ascii_can_line_framer_filter.sv */
// Frames a stream of received ASCII serial bytes and forwards selected lines.
// Bytes are discarded until a start byte 'e' arrives; the following bytes are
// stored until a carriage return. A line whose carriage return sits at an
// index of at least csr min_length (and at least 6) and whose bytes 3..5 read
// "F11" goes out as "$__CAN," followed by line bytes 3 through the carriage
// return, with out_last set on the carriage return. Shorter or non-matching
// lines, and lines that fill MAX_FRAME bytes without a carriage return, are
// dropped silently. The front end takes one request per cycle into one of two
// frame buffers held in a single memory; a finished line is queued and the
// back end streams it out at one byte per cycle while the receiver is ready,
// so a line whose carriage return sits at index n leaves as n + 5 bytes.
// Requests stall only while one line is being sent and a second one waits in
// the queue, since both buffers are then held.
// The min_length register (reset value 26) must be written while the block is
// idle.
module ascii_can_line_framer_filter #(
   parameter int MAX_FRAME = acf_pkg::MAX_FRAME_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   acf_req_if.sink                       req_ch,
   acf_rsp_if.source                     rsp_ch,
   input  logic                          csr_wr_en,
   input  logic [acf_pkg::MIN_LEN_W-1:0] csr_wr_data
);

   // Two buffers of MAX_FRAME bytes each, addressed as {buffer, index}.
   localparam int ADDR_W = $clog2(MAX_FRAME) + 1;
   localparam int DEPTH  = 2 ** ADDR_W;

   logic                       ram_we;
   logic [ADDR_W-1:0]          ram_waddr;
   logic [acf_pkg::DATA_W-1:0] ram_wdata;
   logic                       ram_re;
   logic [ADDR_W-1:0]          ram_raddr;
   logic [acf_pkg::DATA_W-1:0] ram_rdata;

   logic                       push;
   acf_pkg::job_type           push_job;
   logic                       pop;
   acf_pkg::job_type           head;
   logic [1:0]                 q_count;
   logic                       back_busy;
   logic                       bank_free;

   // A buffer is held by every queued line and by the line being sent. The
   // front end's current buffer is free whenever fewer than two are held.
   assign bank_free = (q_count == 2'd0) || (q_count == 2'd1 && !back_busy);

   acf_front #(
      .MAX_FRAME(MAX_FRAME)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .bank_free   (bank_free),
      .ram_we      (ram_we),
      .ram_waddr   (ram_waddr),
      .ram_wdata   (ram_wdata),
      .push        (push),
      .push_job    (push_job)
   );

   acf_ram #(
      .WIDTH(acf_pkg::DATA_W),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock    (clock),
      .we       (ram_we),
      .waddr    (ram_waddr),
      .wdata    (ram_wdata),
      .re       (ram_re),
      .raddr    (ram_raddr),
      .rdata_ff (ram_rdata)
   );

   acf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .count_ff (q_count)
   );

   acf_back #(
      .MAX_FRAME(MAX_FRAME)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_ready (q_count != 2'd0),
      .job       (head),
      .pop       (pop),
      .busy      (back_busy),
      .ram_re    (ram_re),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata),
      .rsp_ch    (rsp_ch)
   );

endmodule

/* tb/sv/acf_line_checker.sv */
module acf_line_checker (
   input  logic                          clock,
   input  logic                          reset,
   acf_req_if                            req_mon,
   acf_rsp_if                            rsp_mon,
   input  logic                          csr_wr_en,
   input  logic [acf_pkg::MIN_LEN_W-1:0] csr_wr_data,
   output int                            mismatch_count,
   output int                            beats_pending
);
   import acf_pkg::*;

   typedef struct packed {
      logic [DATA_W-1:0] data;
      logic              last;
   } can_beat_type;

   localparam logic [8*HDR_LEN-1:0] CAN_PREFIX = "$__CAN,";
   localparam int REPORT_LIMIT = 10;

   logic [DATA_W-1:0]    line_buf [MAX_FRAME_DEF];
   logic [LEN_W-1:0]     line_len;
   logic                 in_line;
   logic [MIN_LEN_W-1:0] min_len_q;
   can_beat_type         expected_beats [$];

   // Advances the line framer by one received byte and queues any beats it releases.
   task automatic frame_byte(input logic [DATA_W-1:0] b);
      int idx;
      int i;
      if (!in_line) begin
         if (b == START_BYTE) begin
            line_buf[0] = b;
            line_len    = LEN_W'(1);
            in_line     = 1'b1;
         end
      end else if (b == CR_BYTE) begin
         idx = int'(line_len);
         if (idx >= int'(min_len_q) && idx >= MIN_HDR_IDX && idx < MAX_FRAME_DEF &&
             line_buf[FIRST_COPIED] == CHAR_F && line_buf[FIRST_COPIED+1] == CHAR_1 &&
             line_buf[FIRST_COPIED+2] == CHAR_1) begin
            for (i = 0; i < HDR_LEN; i++)
               expected_beats.push_back({CAN_PREFIX[8*(HDR_LEN-1-i) +: 8], 1'b0});
            for (i = FIRST_COPIED; i < idx; i++)
               expected_beats.push_back({line_buf[i], 1'b0});
            expected_beats.push_back({CR_BYTE, 1'b1});
         end
         in_line  = 1'b0;
         line_len = '0;
      end else begin
         if (int'(line_len) < MAX_FRAME_DEF) begin
            line_buf[line_len] = b;
            line_len           = line_len + LEN_W'(1);
         end
         if (int'(line_len) >= MAX_FRAME_DEF) begin
            in_line  = 1'b0;
            line_len = '0;
         end
      end
   endtask

   always @(posedge clock) begin
      can_beat_type want;
      can_beat_type got;
      if (reset) begin
         in_line   = 1'b0;
         line_len  = '0;
         min_len_q = MIN_LEN_RESET;
         expected_beats.delete();
         mismatch_count <= 0;
      end else begin
         if (csr_wr_en)
            min_len_q = csr_wr_data;
         // Beats leaving now were predicted by earlier requests, so compare first.
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = {rsp_mon.out_byte, rsp_mon.out_last};
            if (expected_beats.size() == 0) begin
               if (mismatch_count < REPORT_LIMIT)
                  $display("unexpected beat: byte %h last %b", got.data, got.last);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = expected_beats.pop_front();
               if (got != want) begin
                  if (mismatch_count < REPORT_LIMIT)
                     $display("beat mismatch: expected byte %h last %b, got byte %h last %b",
                              want.data, want.last, got.data, got.last);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            frame_byte(req_mon.rx_byte);
      end
      beats_pending <= expected_beats.size();
   end

endmodule

/* tb/sv/tb_ascii_can_line_framer_filter.sv */
module tb_ascii_can_line_framer_filter;
   import acf_pkg::*;

   // Cycles left for the block after the last expected beat; a dropped line
   // still passes through the front end, and a longest message must still
   // leave the back end.
   localparam int SETTLE_CYCLES = 80;
   // Hard stop, far beyond the slowest passing run.
   localparam int RUN_LIMIT = 1_000_000;
   localparam int SEGMENTS = 9;
   localparam int SEGMENT_REQUESTS = 36;

   typedef enum {
      LINE_GOOD,
      LINE_SHORT,
      LINE_BAD_HDR,
      LINE_OVERLONG,
      LINE_NOISE
   } line_kind_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [MIN_LEN_W-1:0] csr_wr_data;

   int send_idle_pct;
   int recv_idle_pct;
   int min_len_cur;
   int mismatch_count;
   int beats_pending;

   acf_req_if req_bus ();
   acf_rsp_if rsp_bus ();

   ascii_can_line_framer_filter u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_bus),
      .rsp_ch      (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   acf_line_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .beats_pending  (beats_pending)
   );

   always #1 clock = ~clock;

   // The receiver drops ready at random, one decision per cycle, at the rate
   // of the current idling phase.
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Any byte but a carriage return, so that a line is not cut short. Now and
   // then it is a start byte, which must be stored like any other byte inside a line.
   function automatic logic [DATA_W-1:0] any_data_byte();
      logic [DATA_W-1:0] b;
      b = DATA_W'($urandom_range(255));
      if ($urandom_range(19) == 0)
         b = START_BYTE;
      else if (b == CR_BYTE)
         b = b ^ 8'h80;
      return b;
   endfunction

   // Offers one request, after a random number of idle cycles, and returns
   // at the clock edge where it is accepted. Valid stays high on return so
   // that back-to-back requests need no gap.
   task automatic push_byte(input logic [DATA_W-1:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.rx_byte <= b;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
   endtask

   // Sends a line whose carriage return lands at index cr_idx. Bytes 3..5
   // carry the "F11" tag unless hdr_ok is clear, in which case one of them
   // is replaced by some other byte. A cr_idx of MAX_FRAME_DEF overflows the
   // line, and the trailing carriage return then arrives while hunting.
   task automatic send_line(input int cr_idx, input bit hdr_ok);
      int bad_pos;
      int i;
      logic [DATA_W-1:0] b;
      logic [DATA_W-1:0] c;
      bad_pos = hdr_ok ? -1 : int'($urandom_range(FIRST_COPIED + 2, FIRST_COPIED));
      for (i = 0; i < cr_idx; i++) begin
         case (i)
            0:                                 b = START_BYTE;
            FIRST_COPIED:                      b = CHAR_F;
            FIRST_COPIED + 1, FIRST_COPIED + 2: b = CHAR_1;
            default:                           b = any_data_byte();
         endcase
         if (i == bad_pos) begin
            c = any_data_byte();
            b = (c == b) ? (b ^ 8'h01) : c;
         end
         push_byte(b);
      end
      push_byte(CR_BYTE);
   endtask

   // Waits until every predicted beat has been taken, then lets the block settle.
   // The first edge lets the checker count a request accepted just before.
   task automatic wait_drained();
      @(posedge clock);
      while (beats_pending != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // The register is only written with the block idle and hunting; every
   // caller has just closed its line with a carriage return.
   task automatic set_min_len(input int v);
      req_bus.valid <= 1'b0;
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= MIN_LEN_W'(v);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      min_len_cur = v;
   endtask

   // Tagged line with a start byte inside it and both byte extremes in the body.
   task automatic push_extreme_line();
      push_byte(START_BYTE);
      push_byte(START_BYTE);
      push_byte(8'hFF);
      push_byte(CHAR_F);
      push_byte(CHAR_1);
      push_byte(CHAR_1);
      push_byte(8'h00);
      push_byte(8'hFF);
      push_byte(CR_BYTE);
   endtask

   // Random traffic: mostly well-formed tagged lines of random content, with
   // short, mistagged and overlong lines and loose noise mixed in.
   task automatic run_segment(input int budget);
      int sent;
      int lo;
      int hi;
      int len;
      int n;
      int i;
      line_kind_type kind;
      int r;
      sent = 0;
      while (sent < budget) begin
         r  = $urandom_range(99);
         kind = (r < 60) ? LINE_GOOD : (r < 72) ? LINE_SHORT : (r < 84) ? LINE_BAD_HDR :
                (r < 90) ? LINE_OVERLONG : LINE_NOISE;
         lo = (min_len_cur > MIN_HDR_IDX) ? min_len_cur : MIN_HDR_IDX;
         if (lo > MAX_FRAME_DEF - 1)
            lo = MIN_HDR_IDX;
         // Lines just past the threshold are favored; the longest come now and then.
         hi = ($urandom_range(1) == 0 && lo + 8 < MAX_FRAME_DEF - 1) ? lo + 8 : MAX_FRAME_DEF - 1;
         case (kind)
            LINE_GOOD: begin
               len = $urandom_range(hi, lo);
               send_line(len, 1'b1);
               sent += len + 1;
            end
            LINE_SHORT: begin
               lo  = (min_len_cur > MIN_HDR_IDX) ? min_len_cur : MIN_HDR_IDX;
               len = $urandom_range(lo - 1, 1);
               send_line(len, 1'b1);
               sent += len + 1;
            end
            LINE_BAD_HDR: begin
               len = $urandom_range(hi, lo);
               send_line(len, 1'b0);
               sent += len + 1;
            end
            LINE_OVERLONG: begin
               send_line(MAX_FRAME_DEF, 1'b1);
               sent += MAX_FRAME_DEF + 1;
            end
            default: begin
               n = $urandom_range(4, 1);
               for (i = 0; i < n; i++)
                  push_byte(DATA_W'($urandom_range(255)));
               push_byte(CR_BYTE);
               sent += n + 1;
            end
         endcase
      end
   endtask

   initial begin
      int seg;
      int plan [5];
      plan = '{56, 63, 0, 6, 26};
      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.rx_byte <= '0;
      csr_wr_en     <= 1'b0;
      csr_wr_data   <= '0;
      send_idle_pct = 17;
      recv_idle_pct = 45;
      min_len_cur   = int'(MIN_LEN_RESET);
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part. A carriage return and an all-ones byte while hunting
      // are both discarded.
      push_byte(CR_BYTE);
      push_byte(8'hFF);
      // At the reset threshold the tagged line is too short and is dropped.
      push_extreme_line();
      // At the lowest threshold the same line goes out with its prefix.
      set_min_len(MIN_HDR_IDX);
      push_extreme_line();
      // A line that is long enough but tagged "F10" gives nothing.
      push_byte(START_BYTE);
      push_byte(8'h00);
      push_byte(8'h00);
      push_byte(CHAR_F);
      push_byte(CHAR_1);
      push_byte(8'h30);
      push_byte(CR_BYTE);
      // With no threshold at all, a line ending before the tag is complete
      // is still dropped.
      set_min_len(0);
      push_byte(START_BYTE);
      push_byte(CHAR_F);
      push_byte(CHAR_1);
      push_byte(CR_BYTE);

      // Random part in three idling phases: sender light and receiver heavy,
      // then the other way round, then no idling at all.
      for (seg = 0; seg < SEGMENTS; seg++) begin
         if (seg == 3) begin
            send_idle_pct = 45;
            recv_idle_pct = 17;
         end else if (seg == 6) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         set_min_len((seg < 5) ? plan[seg] : int'($urandom_range(56, 6)));
         run_segment(SEGMENT_REQUESTS);
      end

      req_bus.valid <= 1'b0;
      wait_drained();
      if (mismatch_count == 0 && beats_pending == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #(RUN_LIMIT);
      $display("status: fail");
      $finish;
   end

endmodule

/* sim.f */
sv/acf_pkg.sv
sv/acf_chan_if.sv
sv/acf_ram.sv
sv/acf_front.sv
sv/acf_queue.sv
sv/acf_back.sv
sv/ascii_can_line_framer_filter.sv
tb/sv/acf_line_checker.sv
tb/sv/tb_ascii_can_line_framer_filter.sv
